### rtl/core/tsr_pkg.sv
// ============================================================================
// tsr_pkg
// Shared types and constants for the timestamp ring with nearest search.
// ============================================================================
package tsr_pkg;

    localparam int unsigned SLOT_W          = 10;
    localparam int unsigned WIN_W           = 16;
    localparam int unsigned STAMP_W         = 32;
    localparam int unsigned CFG_W           = 16;
    localparam int unsigned REG_IDX_W       = 1;

    localparam int unsigned DEFAULT_DEPTH   = 512;
    localparam int unsigned DEFAULT_TIME_W  = 32;
    localparam int unsigned DEFAULT_ENTRIES = 500;
    localparam logic [WIN_W-1:0] DEFAULT_WINDOW = 16'd15;

    localparam logic [REG_IDX_W-1:0] REG_MAX_ENTRIES  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_MATCH_WINDOW = 1'b1;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [STAMP_W-1:0] stamp;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_id;
        logic              hit;
    } out_item_t;

    typedef struct packed {
        logic              write;
        logic              lookup;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] count;
        logic [SLOT_W-1:0] base;
        logic [SLOT_W-1:0] limit;
        logic [WIN_W-1:0]  window;
    } eng_req_t;

    typedef struct packed {
        logic      busy;
        logic      done;
        out_item_t result;
    } eng_rsp_t;

endpackage

### rtl/core/tsr_engine.sv
// ============================================================================
// tsr_engine
// Stamp memory and binary search sequencer for the timestamp ring.
// ============================================================================
module tsr_engine
    import tsr_pkg::*;
#(
    parameter int unsigned DEPTH      = DEFAULT_DEPTH,
    parameter int unsigned TIME_WIDTH = DEFAULT_TIME_W
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  eng_req_t           req,
    input  logic [STAMP_W-1:0] stamp,
    input  logic               take,
    output eng_rsp_t           rsp
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_STEP = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_NB   = 3'd3;
    localparam logic [2:0] S_POS  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [TIME_WIDTH-1:0] mem [DEPTH];
    logic [TIME_WIDTH-1:0] rdata_reg;
    logic [TIME_WIDTH-1:0] query_reg, query_next;

    logic [2:0]        state_reg, state_next;
    logic [SLOT_W-1:0] lo_reg, lo_next;
    logic [SLOT_W-1:0] hi_reg, hi_next;
    logic [SLOT_W-1:0] mid_reg, mid_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] base_reg, base_next;
    logic [SLOT_W-1:0] limit_reg, limit_next;
    logic [WIN_W-1:0]  window_reg, window_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              res_hit_reg, res_hit_next;

    logic [SLOT_W:0]       mid_sum;
    logic [SLOT_W-1:0]     mid;
    logic [SLOT_W-1:0]     log_sel;
    logic [SLOT_W:0]       phys_sum;
    logic [SLOT_W-1:0]     phys;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [TIME_WIDTH-1:0] diff;
    logic                  below;
    logic                  in_window;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[SLOT_W:1];

    always_comb
    begin
        phys_sum = {1'b0, base_reg} + {1'b0, log_sel};
        if (phys_sum >= {1'b0, limit_reg})
        begin
            phys_sum = phys_sum - {1'b0, limit_reg};
        end
        phys = phys_sum[SLOT_W-1:0];
    end

    assign rd_addr = AW'(phys);

    assign below     = rdata_reg < query_reg;
    assign diff      = below ? (query_reg - rdata_reg) : (rdata_reg - query_reg);
    assign in_window = diff <= TIME_WIDTH'(window_reg);

    always_comb
    begin
        state_next    = state_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        slot_next     = slot_reg;
        base_next     = base_reg;
        limit_next    = limit_reg;
        window_next   = window_reg;
        query_next    = query_reg;
        res_slot_next = res_slot_reg;
        res_hit_next  = res_hit_reg;
        log_sel       = lo_reg;
        rd_en         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.lookup)
                begin
                    query_next  = TIME_WIDTH'(stamp);
                    base_next   = req.base;
                    limit_next  = req.limit;
                    window_next = req.window;
                    lo_next     = '0;
                    hi_next     = req.count - SLOT_W'(1);
                    if (req.count == '0)
                    begin
                        res_slot_next = '0;
                        res_hit_next  = 1'b0;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
            end
            S_STEP:
            begin
                rd_en = 1'b1;
                if (lo_reg < hi_reg)
                begin
                    log_sel    = mid;
                    mid_next   = mid;
                    state_next = S_CMP;
                end
                else if (lo_reg != '0)
                begin
                    log_sel    = lo_reg - SLOT_W'(1);
                    slot_next  = phys + SLOT_W'(1);
                    state_next = S_NB;
                end
                else
                begin
                    slot_next  = phys + SLOT_W'(1);
                    state_next = S_POS;
                end
            end
            S_CMP:
            begin
                if (below)
                begin
                    lo_next = mid_reg + SLOT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_STEP;
            end
            S_NB:
            begin
                if (in_window)
                begin
                    res_slot_next = slot_reg;
                    res_hit_next  = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    slot_next  = phys + SLOT_W'(1);
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                res_slot_next = in_window ? slot_reg : '0;
                res_hit_next  = in_window;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        slot_reg     <= slot_next;
        base_reg     <= base_next;
        limit_reg    <= limit_next;
        window_reg   <= window_next;
        query_reg    <= query_next;
        res_slot_reg <= res_slot_next;
        res_hit_reg  <= res_hit_next;
    end

    always_ff @(posedge clk)
    begin
        if (req.write)
        begin
            mem[AW'(req.slot - SLOT_W'(1))] <= TIME_WIDTH'(stamp);
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rsp.busy           = state_reg != S_IDLE;
    assign rsp.done           = state_reg == S_OUT;
    assign rsp.result.slot_id = res_slot_reg;
    assign rsp.result.hit     = res_hit_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP || state_reg == S_CMP) |-> lo_reg <= hi_reg)
        else $error("search bounds crossed");

    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> phys < limit_reg)
        else $error("read beyond ring");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req.lookup || req.write) |-> state_reg == S_IDLE)
        else $error("request while searching");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && res_hit_reg) |-> res_slot_reg != '0)
        else $error("hit without slot");

endmodule

### rtl/core/timestamp_ring_nearest_search.sv
// ============================================================================
// timestamp_ring_nearest_search
// Ring of record timestamps with a nearest-entry lookup by binary search.
// ============================================================================
//
//  channel   direction  handshake                 beat
//  item      in         item_valid / item_ready   operation, stamp
//  result    out        result_valid / result_ready  slot_id, hit
//  cfg       in         cfg_write                 cfg_index, cfg_data
//
//  A record beat writes memory and loads the result in the same cycle.
//  A lookup binary-searches the n entries, then checks the entry below the found
//  position, if any, and on a miss the position itself; an empty ring answers a miss.
//  The single read port means each search step is one read and one compare.
//  Reset empties the ring; no clearing pass, stamps are only read once written.
//  A result waiting on a stalled output holds off the next beat.
//
module timestamp_ring_nearest_search
    import tsr_pkg::*;
#(
    parameter int unsigned DEPTH      = DEFAULT_DEPTH,
    parameter int unsigned TIME_WIDTH = DEFAULT_TIME_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  in_item_t             item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output out_item_t            result,
    input  logic                 cfg_write,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic [SLOT_W-1:0] ENTRIES_RST =
        SLOT_W'((DEFAULT_ENTRIES > DEPTH) ? DEPTH : DEFAULT_ENTRIES);

    logic [SLOT_W-1:0] max_entries_reg, max_entries_next;
    logic [WIN_W-1:0]  window_reg, window_next;
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic              full_reg, full_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    eng_req_t          req;
    eng_rsp_t          rsp;
    logic              out_free;
    logic              accept;
    logic              take;
    logic [SLOT_W-1:0] cfg_entries;

    assign out_free   = !out_valid_reg || result_ready;
    assign item_ready = !rsp.busy && out_free;
    assign accept     = item_valid && item_ready;
    assign take       = rsp.done && out_free;
    assign cfg_entries = cfg_data[SLOT_W-1:0];

    always_comb
    begin
        req.write  = accept && (item.operation == OP_RECORD);
        req.lookup = accept && (item.operation == OP_LOOKUP);
        req.slot   = write_slot_reg;
        req.count  = full_reg ? max_entries_reg : (write_slot_reg - SLOT_W'(1));
        req.base   = full_reg ? (write_slot_reg - SLOT_W'(1)) : '0;
        req.limit  = max_entries_reg;
        req.window = window_reg;
    end

    always_comb
    begin
        max_entries_next = max_entries_reg;
        window_next      = window_reg;
        write_slot_next  = write_slot_reg;
        full_next        = full_reg;
        out_valid_next   = out_valid_reg && !result_ready;
        out_next         = out_reg;

        if (req.write)
        begin
            out_valid_next   = 1'b1;
            out_next.slot_id = write_slot_reg;
            out_next.hit     = 1'b1;
            if (write_slot_reg >= max_entries_reg)
            begin
                write_slot_next = SLOT_W'(1);
                full_next       = 1'b1;
            end
            else
            begin
                write_slot_next = write_slot_reg + SLOT_W'(1);
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b1;
            out_next       = rsp.result;
        end

        if (cfg_write)
        begin
            case (cfg_index)
                REG_MAX_ENTRIES:
                begin
                    if (cfg_entries != '0)
                    begin
                        if (32'(cfg_entries) > 32'(DEPTH))
                        begin
                            max_entries_next = SLOT_W'(DEPTH);
                        end
                        else
                        begin
                            max_entries_next = cfg_entries;
                        end
                        write_slot_next = SLOT_W'(1);
                        full_next       = 1'b0;
                    end
                end
                REG_MATCH_WINDOW:
                begin
                    window_next = cfg_data[WIN_W-1:0];
                end
                default:
                begin
                    window_next = window_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= ENTRIES_RST;
            window_reg      <= DEFAULT_WINDOW;
            write_slot_reg  <= SLOT_W'(1);
            full_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            max_entries_reg <= max_entries_next;
            window_reg      <= window_next;
            write_slot_reg  <= write_slot_next;
            full_reg        <= full_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    tsr_engine #(
        .DEPTH      (DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .stamp (item.stamp),
        .take  (take),
        .rsp   (rsp)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
